### design/fault_blink_code_encoder_top_macros.svh
// Assertion macros for the blink code encoder.
`ifndef FAULT_BLINK_CODE_ENCODER_TOP_MACROS_SVH
`define FAULT_BLINK_CODE_ENCODER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define FBCE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fbce assertion failed");
`define FBCE_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fbce assertion failed");
`else
`define FBCE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`define FBCE_ASSERT_SAME(lbl, clk, rst, ante, cons)
`endif

`endif

### design/fbce_pkg.sv
`default_nettype none

package fbce_pkg;

   localparam int unsigned MsWidth       = 16;
   localparam int unsigned CodeWidth     = 8;
   localparam int unsigned TimeWidth     = MsWidth + 1;
   localparam int unsigned LongWidth     = 5;
   localparam int unsigned FlashWidth    = 6;
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned TensShift     = 11;

   localparam logic [CodeWidth-1:0] CodeBase  = 8'd10;
   localparam logic [CodeWidth-1:0] TensRecip = 8'd205;

   localparam logic [MsWidth-1:0] LongFlashReset = 16'd1000;
   localparam logic [MsWidth-1:0] ShortFlashReset = 16'd250;
   localparam logic [MsWidth-1:0] InterFlashReset = 16'd250;
   localparam logic [MsWidth-1:0] RepeatGapReset = 16'd2000;
   localparam logic [MsWidth-1:0] HbOnReset = 16'd50;
   localparam logic [MsWidth-1:0] HbPeriodReset = 16'd1000;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_LONG_FLASH  = 3'd0,
      CSR_SHORT_FLASH = 3'd1,
      CSR_INTER_FLASH = 3'd2,
      CSR_REPEAT_GAP  = 3'd3,
      CSR_HB_ON       = 3'd4,
      CSR_HB_PERIOD   = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_FLASH = 2'd0,
      PH_INTER = 2'd1,
      PH_GAP   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      WALK_IDLE = 2'd0,
      WALK_RUN  = 2'd1,
      WALK_HOLD = 2'd2
   } walk_state_type;

   typedef struct packed {
      logic [MsWidth-1:0] long_flash_ms;
      logic [MsWidth-1:0] short_flash_ms;
      logic [MsWidth-1:0] inter_flash_ms;
      logic [MsWidth-1:0] repeat_gap_ms;
      logic [MsWidth-1:0] heartbeat_on_ms;
      logic [MsWidth-1:0] heartbeat_period_ms;
   } cfg_type;

   typedef struct packed {
      logic idle;
      logic done;
      logic lit;
   } walk_status_type;

   function automatic logic [MsWidth-1:0] at_least_one(input logic [MsWidth-1:0] value);
      return (value == '0) ? MsWidth'(1) : value;
   endfunction

   // code / 10 by reciprocal multiply, exact for 8-bit codes
   function automatic logic [LongWidth-1:0] code_tens(input logic [CodeWidth-1:0] code);
      logic [2*CodeWidth-1:0] prod;
      prod = (2*CodeWidth)'(code) * (2*CodeWidth)'(TensRecip);
      return prod[TensShift +: LongWidth];
   endfunction

   function automatic logic [FlashWidth-1:0] code_total(input logic [CodeWidth-1:0] code);
      logic [LongWidth-1:0] tens;
      logic [CodeWidth-1:0] tens_x10;
      logic [CodeWidth-1:0] ones;
      tens     = code_tens(code);
      tens_x10 = (CodeWidth'(tens) << 3) + (CodeWidth'(tens) << 1);
      ones     = code - tens_x10;
      return FlashWidth'(tens) + FlashWidth'(ones);
   endfunction

endpackage

`default_nettype wire

### design/fbce_phase_walker.sv
`default_nettype none

module fbce_phase_walker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic [fbce_pkg::MsWidth-1:0]      elapsed_ms,
   input  wire logic [fbce_pkg::CodeWidth-1:0]    fault_code,
   input  wire fbce_pkg::cfg_type                 cfg,
   input  wire logic                              out_free,
   output fbce_pkg::walk_status_type              status
);

   import fbce_pkg::*;

   walk_state_type          state_ff, state_in;
   phase_type               phase_ff, phase_in;
   logic [TimeWidth-1:0]    phase_time_ff, phase_time_in;
   logic [CodeWidth-1:0]    shown_code_ff, shown_code_in;
   logic [LongWidth-1:0]    long_count_ff, long_count_in;
   logic [FlashWidth-1:0]   flash_total_ff, flash_total_in;
   logic [FlashWidth-1:0]   flash_index_ff, flash_index_in;
   logic [CodeWidth-1:0]    code_ff, code_in;
   logic                    lit_ff, lit_in;

   logic [MsWidth-1:0]      dur;
   logic                    hit;
   logic [TimeWidth-1:0]    remain;
   logic [FlashWidth-1:0]   index_next;
   logic                    heartbeat;

   assign heartbeat = (shown_code_ff == '0);

   always_comb begin
      dur = '0;
      unique case (phase_ff)
         PH_FLASH: begin
            if (heartbeat) begin
               dur = at_least_one(cfg.heartbeat_on_ms);
            end else if (flash_index_ff < FlashWidth'(long_count_ff)) begin
               dur = at_least_one(cfg.long_flash_ms);
            end else begin
               dur = at_least_one(cfg.short_flash_ms);
            end
         end
         PH_INTER: begin
            dur = at_least_one(cfg.inter_flash_ms);
         end
         PH_GAP: begin
            if (!heartbeat) begin
               dur = at_least_one(cfg.repeat_gap_ms);
            end else if (cfg.heartbeat_period_ms > cfg.heartbeat_on_ms) begin
               dur = cfg.heartbeat_period_ms - cfg.heartbeat_on_ms;
            end else begin
               dur = MsWidth'(1);
            end
         end
         default: begin
            dur = '0;
         end
      endcase
   end

   assign hit        = phase_time_ff < {1'b0, dur};
   assign remain     = phase_time_ff - {1'b0, dur};
   assign index_next = flash_index_ff + FlashWidth'(1);

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      phase_time_in  = phase_time_ff;
      shown_code_in  = shown_code_ff;
      long_count_in  = long_count_ff;
      flash_total_in = flash_total_ff;
      flash_index_in = flash_index_ff;
      code_in        = code_ff;
      lit_in         = lit_ff;
      unique case (state_ff)
         WALK_IDLE: begin
            if (start) begin
               phase_time_in = phase_time_ff + TimeWidth'(elapsed_ms);
               code_in       = fault_code;
               state_in      = WALK_RUN;
            end
         end
         WALK_RUN: begin
            unique case (phase_ff)
               PH_FLASH: begin
                  if (hit) begin
                     lit_in   = 1'b1;
                     state_in = WALK_HOLD;
                  end else begin
                     phase_time_in  = remain;
                     flash_index_in = index_next;
                     phase_in       = (index_next >= flash_total_ff) ? PH_GAP : PH_INTER;
                  end
               end
               PH_INTER: begin
                  if (hit) begin
                     lit_in   = 1'b0;
                     state_in = WALK_HOLD;
                  end else begin
                     phase_time_in = remain;
                     phase_in      = PH_FLASH;
                  end
               end
               PH_GAP: begin
                  if (hit) begin
                     lit_in   = 1'b0;
                     state_in = WALK_HOLD;
                  end else begin
                     phase_time_in  = remain;
                     shown_code_in  = code_ff;
                     flash_index_in = '0;
                     phase_in       = PH_FLASH;
                     if (code_ff == '0) begin
                        long_count_in  = '0;
                        flash_total_in = FlashWidth'(1);
                     end else begin
                        long_count_in  = code_tens(code_ff);
                        flash_total_in = code_total(code_ff);
                     end
                  end
               end
               default: begin
                  lit_in   = 1'b0;
                  state_in = WALK_HOLD;
               end
            endcase
         end
         WALK_HOLD: begin
            if (out_free) begin
               state_in = WALK_IDLE;
            end
         end
         default: begin
            state_in = WALK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= WALK_IDLE;
         phase_ff       <= PH_FLASH;
         phase_time_ff  <= '0;
         shown_code_ff  <= '0;
         long_count_ff  <= '0;
         flash_total_ff <= FlashWidth'(1);
         flash_index_ff <= '0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         phase_time_ff  <= phase_time_in;
         shown_code_ff  <= shown_code_in;
         long_count_ff  <= long_count_in;
         flash_total_ff <= flash_total_in;
         flash_index_ff <= flash_index_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      lit_ff  <= lit_in;
   end

   assign status.idle = (state_ff == WALK_IDLE);
   assign status.done = (state_ff == WALK_HOLD);
   assign status.lit  = lit_ff;

endmodule

`default_nettype wire

### design/fault_blink_code_encoder_top.sv
// Status LED blink code encoder.
// req channel: one transfer per time step, carrying req_elapsed_ms (ms since
// the previous step) and req_fault_code (0 selects the heartbeat pattern).
// rsp channel: one transfer per step, rsp_led_on is the LED state after it.
// csr port: csr_wr_en writes csr_wdata into register csr_index in the same
// cycle; indexes 0..5 are long flash, short flash, inter-flash gap, repeat
// gap, heartbeat on-time and heartbeat period. Write only while idle.
// A step that crosses B phase boundaries is taken from IDLE, walked in RUN
// one boundary at a time, and held in HOLD until the output register takes
// its result; the walker then returns to IDLE. One shared compare/subtract
// unit walks one phase boundary per cycle (at most one boundary per
// millisecond of accumulated phase time, so B is always below 2^17).
// A finished result moves into the output register; the walker then takes
// the next request while that result waits on a stalled receiver, and holds
// a second result until the output register frees up.
// Reset (synchronous) restores the register defaults, the heartbeat pattern
// at the start of its pulse, and empties the output register.
`default_nettype none
`include "fault_blink_code_encoder_top_macros.svh"

module fault_blink_code_encoder_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [fbce_pkg::MsWidth-1:0]          req_elapsed_ms,
   input  wire logic [fbce_pkg::CodeWidth-1:0]        req_fault_code,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_led_on,
   input  wire logic                                  csr_wr_en,
   input  wire logic [fbce_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire logic [fbce_pkg::MsWidth-1:0]          csr_wdata
);

   import fbce_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   walk_status_type  status;
   logic             start;
   logic             out_free;
   logic             load;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_led_on_ff, rsp_led_on_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_LONG_FLASH:  cfg_in.long_flash_ms       = csr_wdata;
            CSR_SHORT_FLASH: cfg_in.short_flash_ms      = csr_wdata;
            CSR_INTER_FLASH: cfg_in.inter_flash_ms      = csr_wdata;
            CSR_REPEAT_GAP:  cfg_in.repeat_gap_ms       = csr_wdata;
            CSR_HB_ON:       cfg_in.heartbeat_on_ms     = csr_wdata;
            CSR_HB_PERIOD:   cfg_in.heartbeat_period_ms = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_flash_ms       <= LongFlashReset;
         cfg_ff.short_flash_ms      <= ShortFlashReset;
         cfg_ff.inter_flash_ms      <= InterFlashReset;
         cfg_ff.repeat_gap_ms       <= RepeatGapReset;
         cfg_ff.heartbeat_on_ms     <= HbOnReset;
         cfg_ff.heartbeat_period_ms <= HbPeriodReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_ready = status.idle;
   assign start     = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign load      = status.done && out_free;

   fbce_phase_walker u_walker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .elapsed_ms (req_elapsed_ms),
      .fault_code (req_fault_code),
      .cfg        (cfg_ff),
      .out_free   (out_free),
      .status     (status)
   );

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_led_on_in = rsp_led_on_ff;
      if (load) begin
         rsp_valid_in  = 1'b1;
         rsp_led_on_in = status.lit;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_led_on_ff <= rsp_led_on_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_led_on = rsp_led_on_ff;

   `FBCE_ASSERT_NEXT(a_busy_after_req, clock, reset, start, !req_ready)
   `FBCE_ASSERT_NEXT(a_result_kept, clock, reset, status.done && !out_free, status.done)
   `FBCE_ASSERT_NEXT(a_load_shows, clock, reset, load, rsp_valid && (rsp_led_on == $past(status.lit)))
   `FBCE_ASSERT_SAME(a_rise_from_walker, clock, reset, $rose(rsp_valid), $past(status.done))

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import fbce_pkg::*;

   localparam int unsigned QuietLimit  = 600000;
   localparam int unsigned DecimalBase = 10;
   localparam int unsigned CapFactor   = 40;
   localparam int unsigned PhaseSteps  = 80;

   typedef struct {
      logic [MsWidth-1:0]   elapsed;
      logic [CodeWidth-1:0] code;
   } blink_step_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [MsWidth-1:0]       req_elapsed_ms = '0;
   logic [CodeWidth-1:0]     req_fault_code = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_led_on;
   logic                     csr_wr_en = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = CSR_LONG_FLASH;
   logic [MsWidth-1:0]       csr_wdata = '0;

   blink_step_type pending_steps[$];
   blink_step_type next_step;
   logic        expected_led[$];
   logic        wanted_led;
   int unsigned steps_issued = 0;
   int unsigned leds_checked = 0;
   int unsigned faults = 0;
   int unsigned send_gap = 0;
   int unsigned stall_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned elapsed_cap = 65535;
   logic        calm = 1'b0;
   logic        long_hold_done = 1'b0;

   cfg_type              timing;
   phase_type            blink_phase;
   logic [31:0]          time_in_phase;
   logic [CodeWidth-1:0] shown_code;
   logic [LongWidth-1:0] long_flashes;
   logic [FlashWidth-1:0] flash_count;
   logic [FlashWidth-1:0] flash_pos;

   fault_blink_code_encoder_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_elapsed_ms (req_elapsed_ms),
      .req_fault_code (req_fault_code),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_led_on     (rsp_led_on),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [MsWidth-1:0] nonzero_ms(input logic [MsWidth-1:0] value);
      return (value == '0) ? MsWidth'(1) : value;
   endfunction

   function automatic logic [MsWidth-1:0] heartbeat_off_ms(input logic [MsWidth-1:0] on_ms,
                                                           input logic [MsWidth-1:0] period_ms);
      return (period_ms > on_ms) ? period_ms - on_ms : MsWidth'(1);
   endfunction

   function automatic void show_code(input logic [CodeWidth-1:0] code);
      shown_code = code;
      if (code == '0) begin
         long_flashes = '0;
         flash_count  = FlashWidth'(1);
      end else begin
         long_flashes = LongWidth'(code / DecimalBase);
         flash_count  = FlashWidth'(code / DecimalBase) + FlashWidth'(code % DecimalBase);
      end
      flash_pos = '0;
   endfunction

   function automatic logic advance_led(input logic [MsWidth-1:0] elapsed,
                                        input logic [CodeWidth-1:0] code);
      logic [31:0] span;
      logic        lit;
      logic        walking;
      lit     = 1'b0;
      walking = 1'b1;
      time_in_phase = time_in_phase + 32'(elapsed);
      while (walking) begin
         case (blink_phase)
            PH_FLASH: begin
               if (shown_code == '0) span = 32'(nonzero_ms(timing.heartbeat_on_ms));
               else if (flash_pos < FlashWidth'(long_flashes))
                  span = 32'(nonzero_ms(timing.long_flash_ms));
               else span = 32'(nonzero_ms(timing.short_flash_ms));
               if (time_in_phase < span) begin
                  lit     = 1'b1;
                  walking = 1'b0;
               end else begin
                  time_in_phase = time_in_phase - span;
                  flash_pos = flash_pos + FlashWidth'(1);
                  if (flash_pos >= flash_count) blink_phase = PH_GAP;
                  else blink_phase = PH_INTER;
               end
            end
            PH_INTER: begin
               span = 32'(nonzero_ms(timing.inter_flash_ms));
               if (time_in_phase < span) walking = 1'b0;
               else begin
                  time_in_phase = time_in_phase - span;
                  blink_phase   = PH_FLASH;
               end
            end
            PH_GAP: begin
               if (shown_code == '0)
                  span = 32'(heartbeat_off_ms(timing.heartbeat_on_ms,
                                              timing.heartbeat_period_ms));
               else span = 32'(nonzero_ms(timing.repeat_gap_ms));
               if (time_in_phase < span) walking = 1'b0;
               else begin
                  time_in_phase = time_in_phase - span;
                  show_code(code);
                  blink_phase = PH_FLASH;
               end
            end
            default: walking = 1'b0;
         endcase
      end
      return lit;
   endfunction

   function automatic logic [CodeWidth-1:0] pick_code();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return 8'd255;
         2: return CodeWidth'(DecimalBase * $urandom_range(1, 25));
         3: return CodeWidth'($urandom_range(1, 9));
         default: return CodeWidth'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic push_step(input logic [MsWidth-1:0] elapsed, input logic [CodeWidth-1:0] code);
      blink_step_type item;
      item.elapsed = elapsed;
      item.code    = code;
      pending_steps.push_back(item);
      steps_issued++;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [MsWidth-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_LONG_FLASH:  timing.long_flash_ms = value;
         CSR_SHORT_FLASH: timing.short_flash_ms = value;
         CSR_INTER_FLASH: timing.inter_flash_ms = value;
         CSR_REPEAT_GAP:  timing.repeat_gap_ms = value;
         CSR_HB_ON:       timing.heartbeat_on_ms = value;
         CSR_HB_PERIOD:   timing.heartbeat_period_ms = value;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [MsWidth-1:0] long_ms, input logic [MsWidth-1:0] short_ms,
                                 input logic [MsWidth-1:0] inter_ms, input logic [MsWidth-1:0] gap_ms,
                                 input logic [MsWidth-1:0] hb_on, input logic [MsWidth-1:0] hb_period);
      int unsigned shortest;
      write_reg(CSR_LONG_FLASH, long_ms);
      write_reg(CSR_SHORT_FLASH, short_ms);
      write_reg(CSR_INTER_FLASH, inter_ms);
      write_reg(CSR_REPEAT_GAP, gap_ms);
      write_reg(CSR_HB_ON, hb_on);
      write_reg(CSR_HB_PERIOD, hb_period);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shortest = nonzero_ms(long_ms);
      if (nonzero_ms(short_ms) < shortest) shortest = nonzero_ms(short_ms);
      if (nonzero_ms(inter_ms) < shortest) shortest = nonzero_ms(inter_ms);
      if (nonzero_ms(gap_ms) < shortest) shortest = nonzero_ms(gap_ms);
      if (nonzero_ms(hb_on) < shortest) shortest = nonzero_ms(hb_on);
      if (heartbeat_off_ms(hb_on, hb_period) < shortest)
         shortest = heartbeat_off_ms(hb_on, hb_period);
      elapsed_cap = (shortest * CapFactor > 65535) ? 65535 : shortest * CapFactor;
   endtask

   task automatic queue_random_steps(input int unsigned count);
      logic [CodeWidth-1:0] held_code;
      logic [MsWidth-1:0]   span;
      held_code = pick_code();
      for (int unsigned n = 0; n < count; n++) begin
         if ($urandom_range(0, 19) == 0) held_code = pick_code();
         case ($urandom_range(0, 7))
            0: span = MsWidth'(elapsed_cap);
            1: span = '0;
            2: span = MsWidth'($urandom_range(0, elapsed_cap / CapFactor));
            default: span = MsWidth'($urandom_range(0, elapsed_cap));
         endcase
         if ($urandom_range(0, 9) == 0) push_step(span, CodeWidth'($urandom_range(0, 255)));
         else push_step(span, held_code);
      end
   endtask

   task automatic drain_results();
      while (leds_checked < steps_issued) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_led.push_back(advance_led(req_elapsed_ms, req_fault_code));
         end
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_steps.size() != 0) begin
               next_step = pending_steps.pop_front();
               req_valid      <= 1'b1;
               req_elapsed_ms <= next_step.elapsed;
               req_fault_code <= next_step.code;
               if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 10);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_led.size() == 0) begin
               faults++;
               if (faults <= 10)
                  $display("response %0d: led_on=%0b arrived with nothing expected",
                           leds_checked, rsp_led_on);
            end else begin
               wanted_led = expected_led.pop_front();
               if (rsp_led_on !== wanted_led) begin
                  faults++;
                  if (faults <= 10)
                     $display("response %0d: led_on expected %0b, got %0b",
                              leds_checked, wanted_led, rsp_led_on);
               end
            end
            leds_checked++;
         end
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else if (!calm && !long_hold_done && leds_checked >= 150) begin
            long_hold_done <= 1'b1;
            stall_left     <= 399;
            rsp_ready      <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 9);
            rsp_ready  <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QuietLimit) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      timing.long_flash_ms       = LongFlashReset;
      timing.short_flash_ms      = ShortFlashReset;
      timing.inter_flash_ms      = InterFlashReset;
      timing.repeat_gap_ms       = RepeatGapReset;
      timing.heartbeat_on_ms     = HbOnReset;
      timing.heartbeat_period_ms = HbPeriodReset;
      show_code('0);
      blink_phase   = PH_FLASH;
      time_in_phase = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      push_step(16'd0, 8'd0);
      push_step(16'd49, 8'd0);
      push_step(16'd1, 8'd0);
      push_step(16'd949, 8'd200);
      push_step(16'd1, 8'd10);
      push_step(16'd3000, 8'd10);
      push_step(16'd6000, 8'd9);
      push_step(16'd2000, 8'd9);
      push_step(16'hFFFF, 8'd255);
      push_step(16'hFFFF, 8'd255);
      push_step(16'hAAAA, 8'd1);
      push_step(16'h5555, 8'd0);
      push_step(16'd40000, 8'd0);
      push_step(16'd1, 8'd0);
      push_step(16'd999, 8'd0);
      push_step(16'h8000, 8'd128);
      push_step(16'h7FFF, 8'd127);
      push_step(16'd0, 8'd0);
      push_step(16'd500, 8'd0);
      drain_results();

      for (int unsigned phase_no = 0; phase_no < 8; phase_no++) begin
         case (phase_no)
            0: apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
            1: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            2: apply_settings(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd2);
            3: apply_settings(16'd60000, 16'd40000, 16'd20000, 16'hFFFF, 16'd30000, 16'hFFFF);
            4: apply_settings(16'd7, 16'd5, 16'd3, 16'd11, 16'd200, 16'd100);
            5: apply_settings(MsWidth'($urandom_range(1, 300)), MsWidth'($urandom_range(1, 300)),
                              MsWidth'($urandom_range(1, 300)), MsWidth'($urandom_range(1, 300)),
                              MsWidth'($urandom_range(1, 300)), MsWidth'($urandom_range(2, 300)));
            6: apply_settings(MsWidth'($urandom_range(1, 65535)),
                              MsWidth'($urandom_range(1, 65535)),
                              MsWidth'($urandom_range(1, 65535)),
                              MsWidth'($urandom_range(1, 65535)),
                              MsWidth'($urandom_range(1, 65535)),
                              MsWidth'($urandom_range(2, 65535)));
            default: begin
               calm = 1'b1;
               apply_settings(LongFlashReset, ShortFlashReset, InterFlashReset,
                              RepeatGapReset, HbOnReset, HbPeriodReset);
            end
         endcase
         queue_random_steps(PhaseSteps);
         drain_results();
      end

      repeat (50) @(posedge clock);
      if (expected_led.size() != 0) faults++;
      if (faults == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
